>>> rtl/core/tad_pkg.sv
// tad_pkg: constants, codes and shared types of the throttle average and
// direction block. No dependencies; used by every other file in rtl/core.
`default_nettype none

package tad_pkg;

   localparam int WINDOW_LOG2  = 3;
   localparam int WINDOW_DEPTH = 1 << WINDOW_LOG2;
   localparam int SAMPLE_W     = 8;
   localparam int SUM_W        = SAMPLE_W + WINDOW_LOG2;
   localparam int TICK_W       = 16;
   localparam int CSR_IDX_W    = 4;
   localparam int CSR_DATA_W   = 16;

   localparam logic [SAMPLE_W:0] ACCEPT_BAND = (SAMPLE_W + 1)'(10);
   localparam logic [7:0]        REJECT_MAX  = 8'hFF;

   localparam logic [7:0]  FRONT_RESET = 8'd89;
   localparam logic [7:0]  REAR_RESET  = 8'd86;
   localparam logic [15:0] WAIT_RESET  = 16'd10;
   localparam logic [7:0]  ERR_RESET   = 8'd5;

   typedef enum logic [1:0] {
      DIR_NEUTRAL = 2'd0,
      DIR_FORWARD = 2'd1,
      DIR_REAR    = 2'd2
   } direction_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRONT_THRESHOLD = 4'd0,
      CSR_REAR_THRESHOLD  = 4'd1,
      CSR_WAIT_TICKS      = 4'd2,
      CSR_ERR_LIMIT       = 4'd3
   } csr_index_type;

   // window controls from the update logic
   typedef struct packed {
      logic                fill;
      logic                store;
      logic [SAMPLE_W-1:0] sample;
   } win_ctl_type;

   // averages seen by the update logic
   typedef struct packed {
      logic [SAMPLE_W-1:0] avg_cur;
      logic [SAMPLE_W-1:0] avg_new;
   } win_stat_type;

endpackage

`default_nettype wire

>>> rtl/core/tad_if.sv
// tad_if: valid/ready channel interfaces for the tick input, the result
// output and the register write port. Depends on tad_pkg.
`default_nettype none

interface tad_req_if;
   logic                          valid;
   logic                          ready;
   logic [tad_pkg::SAMPLE_W-1:0]  pulse_high_time;
   logic [7:0]                    throttle_reading;
   logic [7:0]                    run_mode;
   modport source (output valid, pulse_high_time, throttle_reading, run_mode, input ready);
   modport sink   (input valid, pulse_high_time, throttle_reading, run_mode, output ready);
endinterface

interface tad_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [7:0]                    mode_out;
   tad_pkg::direction_type        direction;
   logic [tad_pkg::SAMPLE_W-1:0]  throttle_average;
   modport source (output valid, mode_out, direction, throttle_average, input ready);
   modport sink   (input valid, mode_out, direction, throttle_average, output ready);
endinterface

interface tad_csr_if;
   logic                             valid;
   logic                             ready;
   logic [tad_pkg::CSR_IDX_W-1:0]    index;
   logic [tad_pkg::CSR_DATA_W-1:0]   data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/tad_cell.sv
// tad_cell: one window entry. Loads the fill sample or takes its
// neighbour's entry on a store. Depends on tad_pkg.
`default_nettype none

module tad_cell (
   input  wire logic                          clock,
   input  wire logic                          fill,
   input  wire logic                          shift,
   input  wire logic [tad_pkg::SAMPLE_W-1:0]  fill_data,
   input  wire logic [tad_pkg::SAMPLE_W-1:0]  prev_data,
   output      logic [tad_pkg::SAMPLE_W-1:0]  data
);

   logic [tad_pkg::SAMPLE_W-1:0] data_ff;
   logic [tad_pkg::SAMPLE_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (fill) begin
         data_in = fill_data;
      end else if (shift) begin
         data_in = prev_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

`default_nettype wire

>>> rtl/core/tad_window.sv
// tad_window: row of tad_cell entries with the running window sum.
// The oldest entry leaves at the far end. Depends on tad_pkg, tad_cell.
`default_nettype none

module tad_window (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire tad_pkg::win_ctl_type  ctl,
   output      tad_pkg::win_stat_type stat
);

   logic [tad_pkg::SAMPLE_W-1:0] cell_data [tad_pkg::WINDOW_DEPTH];
   logic [tad_pkg::SUM_W-1:0]    sum_ff;
   logic [tad_pkg::SUM_W-1:0]    sum_in;

   for (genvar i = 0; i < tad_pkg::WINDOW_DEPTH; i++) begin : g_cell
      tad_cell u_cell (
         .clock     (clock),
         .fill      (ctl.fill),
         .shift     (ctl.store),
         .fill_data (ctl.sample),
         .prev_data ((i == 0) ? ctl.sample : cell_data[(i == 0) ? 0 : i - 1]),
         .data      (cell_data[i])
      );
   end

   always_comb begin
      sum_in = sum_ff;
      if (ctl.fill) begin
         sum_in = {ctl.sample, {tad_pkg::WINDOW_LOG2{1'b0}}};
      end else if (ctl.store) begin
         sum_in = sum_ff
                - tad_pkg::SUM_W'(cell_data[tad_pkg::WINDOW_DEPTH-1])
                + tad_pkg::SUM_W'(ctl.sample);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else begin
         sum_ff <= sum_in;
      end
   end

   assign stat.avg_cur = sum_ff[tad_pkg::SUM_W-1:tad_pkg::WINDOW_LOG2];
   assign stat.avg_new = sum_in[tad_pkg::SUM_W-1:tad_pkg::WINDOW_LOG2];

endmodule

`default_nettype wire

>>> rtl/core/throttle_average_and_direction.sv
// throttle_average_and_direction: tick counting, direction, outlier
// rejection and result register around tad_window. Depends on tad_pkg, tad_if, tad_window.
//
//   channel  dir  transfer carries
//   req_chan in   pulse_high_time, throttle_reading, run_mode (one tick)
//   rsp_chan out  mode_out, direction, throttle_average
//   csr_chan in   index, data (register write, always ready)
//
// One tick per cycle while req_chan is ready; a tick that updates has its result
// in the output register on the next cycle, averaged from the new window sum.
// req_chan is ready whenever the output register is empty or being taken.
// Synchronous reset clears counters, sum and result valid and loads the register
// reset values; window entries fill on the first update.
`default_nettype none

module throttle_average_and_direction (
   input  wire logic  clock,
   input  wire logic  reset,
   tad_req_if.sink    req_chan,
   tad_rsp_if.source  rsp_chan,
   tad_csr_if.sink    csr_chan
);

   logic [7:0]                   front_ff, front_in;
   logic [7:0]                   rear_ff, rear_in;
   logic [tad_pkg::TICK_W-1:0]   wait_ff, wait_in;
   logic [7:0]                   err_ff, err_in;

   logic [tad_pkg::TICK_W-1:0]   tick_ff, tick_in;
   logic                         started_ff, started_in;
   logic [7:0]                   reject_ff, reject_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [7:0]                   mode_ff;
   tad_pkg::direction_type       dir_ff;
   logic [tad_pkg::SAMPLE_W-1:0] avg_ff;

   logic                         req_fire;
   logic                         update;
   logic [tad_pkg::TICK_W:0]     tick_next;
   logic                         in_band;
   tad_pkg::direction_type       dir_now;
   tad_pkg::win_ctl_type         win_ctl;
   tad_pkg::win_stat_type        win_stat;
   logic [tad_pkg::SAMPLE_W:0]   sample_x;
   logic [tad_pkg::SAMPLE_W:0]   avg_x;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   always_comb begin
      front_in = front_ff;
      rear_in  = rear_ff;
      wait_in  = wait_ff;
      err_in   = err_ff;
      if (csr_chan.valid) begin
         case (csr_chan.index)
            tad_pkg::CSR_FRONT_THRESHOLD: front_in = csr_chan.data[7:0];
            tad_pkg::CSR_REAR_THRESHOLD:  rear_in  = csr_chan.data[7:0];
            tad_pkg::CSR_WAIT_TICKS:      wait_in  = csr_chan.data[tad_pkg::TICK_W-1:0];
            tad_pkg::CSR_ERR_LIMIT:       err_in   = csr_chan.data[7:0];
            default: ;
         endcase
      end
   end

   assign tick_next = {1'b0, tick_ff} + (tad_pkg::TICK_W + 1)'(1);
   assign update    = req_fire && !(tick_next < {1'b0, wait_ff});

   always_comb begin
      if (req_chan.throttle_reading >= front_ff) begin
         dir_now = tad_pkg::DIR_FORWARD;
      end else if (req_chan.throttle_reading <= rear_ff) begin
         dir_now = tad_pkg::DIR_REAR;
      end else begin
         dir_now = tad_pkg::DIR_NEUTRAL;
      end
   end

   // strictly inside +-band of the current average
   assign sample_x = {1'b0, req_chan.pulse_high_time};
   assign avg_x    = {1'b0, win_stat.avg_cur};
   assign in_band  = (sample_x < avg_x + tad_pkg::ACCEPT_BAND)
                  && (sample_x + tad_pkg::ACCEPT_BAND > avg_x);

   always_comb begin
      win_ctl.fill   = update && !started_ff;
      win_ctl.store  = update && started_ff && (in_band || reject_ff > err_ff);
      win_ctl.sample = req_chan.pulse_high_time;
   end

   always_comb begin
      tick_in    = tick_ff;
      started_in = started_ff;
      reject_in  = reject_ff;
      if (req_fire) begin
         tick_in = update ? '0 : tick_next[tad_pkg::TICK_W-1:0];
      end
      if (win_ctl.fill) begin
         started_in = 1'b1;
      end
      if (win_ctl.store) begin
         reject_in = '0;
      end else if (update && started_ff && reject_ff != tad_pkg::REJECT_MAX) begin
         reject_in = reject_ff + 8'd1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (update) begin
         rsp_valid_in = 1'b1;
      end
   end

   tad_window u_window (
      .clock (clock),
      .reset (reset),
      .ctl   (win_ctl),
      .stat  (win_stat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= tad_pkg::FRONT_RESET;
         rear_ff      <= tad_pkg::REAR_RESET;
         wait_ff      <= tad_pkg::WAIT_RESET;
         err_ff       <= tad_pkg::ERR_RESET;
         tick_ff      <= '0;
         started_ff   <= 1'b0;
         reject_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         front_ff     <= front_in;
         rear_ff      <= rear_in;
         wait_ff      <= wait_in;
         err_ff       <= err_in;
         tick_ff      <= tick_in;
         started_ff   <= started_in;
         reject_ff    <= reject_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (update) begin
         mode_ff <= req_chan.run_mode;
         dir_ff  <= dir_now;
         avg_ff  <= win_stat.avg_new;
      end
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.mode_out         = mode_ff;
   assign rsp_chan.direction        = dir_ff;
   assign rsp_chan.throttle_average = avg_ff;

   a_rsp_from_update: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff)) |-> $past(update))
      else $error("result appeared without an update");

   a_no_reject_before_fill: assert property (@(posedge clock) disable iff (reset)
      !started_ff |-> (reject_ff == '0))
      else $error("rejections counted before first fill");

   a_tick_cleared: assert property (@(posedge clock) disable iff (reset)
      $past(update) |-> (tick_ff == '0))
      else $error("tick count not cleared after update");

endmodule

`default_nettype wire

>>> sim/tb_top.sv
// tb_top: self-checking bench for throttle_average_and_direction. Ticks, results and
// register writes go over the tad_if channels; a local model predicts every update.
// Depends on tad_pkg, tad_if and the block itself.
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import tad_pkg::*;

   localparam int HALF_PERIOD      = 5;
   localparam int RESET_CYCLES     = 10;
   localparam int SETTLE_CYCLES    = 4;
   localparam int MAX_REPORTS      = 10;
   localparam int RUN_LIMIT_CYCLES = 2_000_000;
   localparam int LONG_TICKS       = 30;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 4'd9;

   typedef struct {
      logic [7:0]    mode;
      direction_type dir;
      logic [7:0]    avg;
   } update_type;

   logic clock;
   logic reset;

   tad_req_if req_chan ();
   tad_rsp_if rsp_chan ();
   tad_csr_if csr_chan ();

   throttle_average_and_direction dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   logic [7:0]             front_q;
   logic [7:0]             rear_q;
   logic [15:0]            wait_q;
   logic [7:0]             err_limit_q;
   logic [7:0]             window_q [WINDOW_DEPTH];
   logic [WINDOW_LOG2-1:0] wr_idx;
   logic [SUM_W-1:0]       sum_q;
   bit                     started_q;
   logic [7:0]             rejects_q;
   logic [7:0]             avg_q;
   logic [15:0]            ticks_q;

   update_type pending_updates [$];
   int         mismatches;
   bit         req_idle_on;
   bit         rsp_idle_on;

   initial begin
      clock = 1'b0;
      forever #HALF_PERIOD clock = ~clock;
   end

   initial begin
      repeat (RUN_LIMIT_CYCLES) @(posedge clock);
      $display("RESULT: ERROR");
      $finish;
   end

   function automatic void apply_register(logic [CSR_IDX_W-1:0] idx, logic [15:0] value);
      case (idx)
         CSR_FRONT_THRESHOLD: front_q     = value[7:0];
         CSR_REAR_THRESHOLD:  rear_q      = value[7:0];
         CSR_WAIT_TICKS:      wait_q      = value;
         CSR_ERR_LIMIT:       err_limit_q = value[7:0];
         default: ;
      endcase
   endfunction

   function automatic void advance_tick(logic [7:0] sample, logic [7:0] reading,
                                        logic [7:0] mode);
      int unsigned   next;
      int            sv;
      int            av;
      direction_type dir;
      update_type    upd;
      next = ticks_q + 1;
      if (next < wait_q) begin
         ticks_q = 16'(next);
         return;
      end
      ticks_q = '0;
      if (reading >= front_q) dir = DIR_FORWARD;
      else if (reading <= rear_q) dir = DIR_REAR;
      else dir = DIR_NEUTRAL;
      if (!started_q) begin
         foreach (window_q[i]) window_q[i] = sample;
         sum_q     = SUM_W'(sample) << WINDOW_LOG2;
         wr_idx    = '0;
         started_q = 1'b1;
      end else begin
         sv = int'(sample);
         av = int'(avg_q);
         if ((sv < av + int'(ACCEPT_BAND) && sv > av - int'(ACCEPT_BAND)) ||
             rejects_q > err_limit_q) begin
            sum_q            = sum_q - SUM_W'(window_q[wr_idx]) + SUM_W'(sample);
            window_q[wr_idx] = sample;
            wr_idx           = wr_idx + 1'b1;
            rejects_q        = '0;
         end else if (rejects_q != REJECT_MAX) begin
            rejects_q++;
         end
      end
      avg_q    = 8'(sum_q / WINDOW_DEPTH);
      upd.mode = mode;
      upd.dir  = dir;
      upd.avg  = avg_q;
      pending_updates.push_back(upd);
   endfunction

   function automatic logic [7:0] offset_sample(int delta);
      int v;
      v = int'(avg_q) + delta;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return 8'(v);
   endfunction

   function automatic logic [7:0] outlier_sample();
      return (avg_q < 8'd128) ? 8'd255 : 8'd0;
   endfunction

   function automatic logic [7:0] offset_reading(logic [7:0] level);
      int v;
      v = int'(level) + $urandom_range(0, 4) - 2;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return 8'(v);
   endfunction

   task automatic note_mismatch(input string what);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("mismatch: %s", what);
   endtask

   always @(posedge clock) begin : check_updates
      update_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_updates.size() == 0) begin
            note_mismatch($sformatf("unexpected transfer mode=%0d dir=%0d avg=%0d",
                          rsp_chan.mode_out, rsp_chan.direction,
                          rsp_chan.throttle_average));
         end else begin
            want = pending_updates.pop_front();
            if (rsp_chan.mode_out !== want.mode)
               note_mismatch($sformatf("mode_out exp %0d got %0d",
                             want.mode, rsp_chan.mode_out));
            if (rsp_chan.direction !== want.dir)
               note_mismatch($sformatf("direction exp %0d got %0d",
                             want.dir, rsp_chan.direction));
            if (rsp_chan.throttle_average !== want.avg)
               note_mismatch($sformatf("throttle_average exp %0d got %0d",
                             want.avg, rsp_chan.throttle_average));
         end
      end
   end

   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_idle_on && $urandom_range(0, 5) == 0) begin
            rsp_chan.ready = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clock);
         end
         rsp_chan.ready = 1'b1;
      end
   end

   task automatic send_tick(input logic [7:0] sample, input logic [7:0] reading,
                            input logic [7:0] mode);
      if (req_idle_on && $urandom_range(0, 4) == 0) begin
         req_chan.valid = 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
      req_chan.valid            = 1'b1;
      req_chan.pulse_high_time  = sample;
      req_chan.throttle_reading = reading;
      req_chan.run_mode         = mode;
      do @(posedge clock); while (!req_chan.ready);
      advance_tick(sample, reading, mode);
      @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx, input logic [15:0] value);
      csr_chan.valid = 1'b1;
      csr_chan.index = idx;
      csr_chan.data  = value;
      do @(posedge clock); while (!csr_chan.ready);
      apply_register(idx, value);
      @(negedge clock);
      csr_chan.valid = 1'b0;
   endtask

   task automatic settle();
      req_chan.valid = 1'b0;
      while (pending_updates.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic test_reset_values();
      repeat (WAIT_RESET) send_tick(8'd200, 8'($urandom), 8'($urandom));
      settle();
   endtask

   // zero interval acts as one; equal thresholds resolve to forward
   task automatic test_direction_thresholds();
      write_register(CSR_WAIT_TICKS, 16'd0);
      write_register(CSR_FRONT_THRESHOLD, {8'($urandom), 8'd100});
      write_register(CSR_REAR_THRESHOLD, {8'($urandom), 8'd100});
      send_tick(8'd0,   8'd0,   8'd0);
      send_tick(8'd255, 8'd99,  8'd255);
      send_tick(8'd128, 8'd100, 8'h55);
      send_tick(8'd127, 8'd101, 8'hAA);
      send_tick(8'd255, 8'd255, 8'd1);
      settle();
      write_register(CSR_FRONT_THRESHOLD, 16'd255);
      write_register(CSR_REAR_THRESHOLD, 16'd0);
      send_tick(8'($urandom), 8'd255, 8'd2);
      send_tick(8'($urandom), 8'd0,   8'd3);
      send_tick(8'($urandom), 8'd128, 8'd4);
      settle();
   endtask

   task automatic test_outlier_band();
      write_register(CSR_WAIT_TICKS, 16'd1);
      write_register(CSR_ERR_LIMIT, 16'd1);
      send_tick(offset_sample(10),  8'($urandom), 8'($urandom));
      send_tick(offset_sample(-10), 8'($urandom), 8'($urandom));
      send_tick(offset_sample(40),  8'($urandom), 8'($urandom));
      send_tick(offset_sample(9),   8'($urandom), 8'($urandom));
      send_tick(offset_sample(-9),  8'($urandom), 8'($urandom));
      settle();
   endtask

   task automatic test_register_decode();
      write_register(CSR_SPARE, 16'($urandom));
      send_tick(8'($urandom), 8'($urandom), 8'($urandom));
      settle();
   endtask

   // counter already past the new interval fires on the next tick
   task automatic test_lowered_interval();
      write_register(CSR_WAIT_TICKS, 16'd50);
      repeat (4) send_tick(8'($urandom), 8'($urandom), 8'($urandom));
      settle();
      write_register(CSR_WAIT_TICKS, 16'd3);
      send_tick(8'($urandom), 8'($urandom), 8'($urandom));
      settle();
   endtask

   task automatic test_reject_saturation();
      write_register(CSR_WAIT_TICKS, 16'd1);
      write_register(CSR_ERR_LIMIT, 16'd255);
      repeat (270) send_tick(outlier_sample(), 8'($urandom), 8'($urandom));
      settle();
      write_register(CSR_ERR_LIMIT, 16'd254);
      repeat (2) send_tick(outlier_sample(), 8'($urandom), 8'($urandom));
      settle();
   endtask

   // widest interval holds off updates; the count then meets a smaller one
   task automatic test_long_interval();
      req_idle_on = 1'b0;
      write_register(CSR_WAIT_TICKS, 16'hFFFF);
      repeat (LONG_TICKS) send_tick(8'($urandom), 8'($urandom), 8'($urandom));
      settle();
      write_register(CSR_WAIT_TICKS, 16'(LONG_TICKS));
      send_tick(8'($urandom), 8'($urandom), 8'($urandom));
      settle();
      req_idle_on = 1'b1;
   endtask

   task automatic test_random_traffic();
      logic [7:0] sample;
      logic [7:0] reading;
      int         pick;
      for (int phase = 0; phase < 6; phase++) begin
         write_register(CSR_FRONT_THRESHOLD, 16'($urandom));
         write_register(CSR_REAR_THRESHOLD, 16'($urandom));
         case ($urandom_range(0, 3))
            0: write_register(CSR_WAIT_TICKS, 16'd1);
            1: write_register(CSR_WAIT_TICKS, 16'($urandom_range(2, 4)));
            2: write_register(CSR_WAIT_TICKS, 16'd0);
            default: write_register(CSR_WAIT_TICKS, 16'($urandom_range(5, 12)));
         endcase
         case ($urandom_range(0, 4))
            0: write_register(CSR_ERR_LIMIT, 16'd0);
            1: write_register(CSR_ERR_LIMIT, 16'd255);
            default: write_register(CSR_ERR_LIMIT, 16'($urandom_range(1, 8)));
         endcase
         if (phase == 5) begin
            req_idle_on = 1'b0;
            rsp_idle_on = 1'b0;
         end
         repeat (70) begin
            if ($urandom_range(0, 3) != 0) sample = offset_sample($urandom_range(0, 28) - 14);
            else sample = 8'($urandom);
            pick = $urandom_range(0, 3);
            if (pick == 0) reading = offset_reading(front_q);
            else if (pick == 1) reading = offset_reading(rear_q);
            else reading = 8'($urandom);
            send_tick(sample, reading, 8'($urandom));
         end
         settle();
      end
   endtask

   initial begin
      reset                     = 1'b1;
      req_chan.valid            = 1'b0;
      req_chan.pulse_high_time  = '0;
      req_chan.throttle_reading = '0;
      req_chan.run_mode         = '0;
      csr_chan.valid            = 1'b0;
      csr_chan.index            = '0;
      csr_chan.data             = '0;
      front_q     = FRONT_RESET;
      rear_q      = REAR_RESET;
      wait_q      = WAIT_RESET;
      err_limit_q = ERR_RESET;
      foreach (window_q[i]) window_q[i] = '0;
      wr_idx      = '0;
      sum_q       = '0;
      started_q   = 1'b0;
      rejects_q   = '0;
      avg_q       = '0;
      ticks_q     = '0;
      mismatches  = 0;
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_values();
      test_direction_thresholds();
      test_outlier_band();
      test_register_decode();
      test_lowered_interval();
      test_reject_saturation();
      test_long_interval();
      test_random_traffic();

      settle();
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire

>>> throttle_average_and_direction.f
rtl/core/tad_pkg.sv
rtl/core/tad_if.sv
rtl/core/tad_cell.sv
rtl/core/tad_window.sv
rtl/core/throttle_average_and_direction.sv
sim/tb_top.sv
